>>> hw/rtl/ngsp_pkg.sv
// Shared types, character codes and helpers for the GGA sentence parser.
`timescale 1ns / 1ps
`default_nettype none

package ngsp_pkg;

    localparam int LINE_CAPACITY = 128;
    localparam int LEN_W         = 8;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    // Byte classes sorted out by the front end.
    typedef logic [1:0] cls_t;
    localparam cls_t CLS_DATA  = 2'd0;
    localparam cls_t CLS_START = 2'd1;
    localparam cls_t CLS_END   = 2'd2;

    // Close status codes.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NONE     = 2'd0;
    localparam kind_t KIND_REJECTED = 2'd1;
    localparam kind_t KIND_GGA      = 2'd2;
    localparam kind_t KIND_OTHER    = 2'd3;

    // Characters.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    // Fixed-point limits and scale factors.
    localparam logic [30:0] COORD_LIMIT = 31'd1810000000;
    localparam logic [19:0] ALT_LIMIT   = 20'd1000000;
    localparam logic [19:0] ALT_OVER    = 20'd1000001;
    localparam logic [31:0] DIV3_MUL    = 32'hAAAAAAAB;
    localparam logic [33:0] DEG_SCALE   = 34'd10000000;
    localparam logic [25:0] MIN_SCALE5  = 26'd500000;

    typedef struct packed {
        logic        valid;
        cls_t        cls;
        logic [7:0]  ch;
    } qport_t;

    typedef struct packed {
        cls_t        cls;
        logic [7:0]  ch;
    } qent_t;

    // Raw pieces of one ddmm.mmmmm coordinate field.
    typedef struct packed {
        logic        present;
        logic        zero;
        logic        big;
        logic [7:0]  deg;
        logic [6:0]  min;
        logic [16:0] frac;
    } coord_raw_t;

    typedef struct packed {
        logic        start;
        coord_raw_t  lat;
        coord_raw_t  lon;
    } coord_req_t;

    typedef struct packed {
        logic        busy;
        logic        valid;
        logic [30:0] lat_mag;
        logic [30:0] lon_mag;
    } coord_rsp_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Returns {valid, value}.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    // Place value of the n-th minute-fraction digit, five digits in all.
    function automatic logic [16:0] frac_weight(input logic [2:0] n);
        logic [16:0] w;
        unique case (n)
            3'd0:    w = 17'd10000;
            3'd1:    w = 17'd1000;
            3'd2:    w = 17'd100;
            3'd3:    w = 17'd10;
            3'd4:    w = 17'd1;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/nmea_gga_sentence_parser_core.sv
// Top level of the NMEA GGA sentence parser.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake        Payload
// request   in         push / full      rx_byte
// result    out        empty / pop      sentence_kind, fix_quality, satellite_count,
//                                       hdop_halves, position_valid, latitude_e7,
//                                       longitude_e7, altitude_dm
//
// Each received byte produces exactly one result. Ordinary bytes, '$' and
// closes that do not yield a position are settled in the back end alone. A
// valid GGA close that carries a position also passes through the shared
// coordinate unit (three steps each for latitude and longitude, then commit).
// A two-entry request queue sits between the classifier and the parser, so
// bytes keep being accepted while the queue has room, even as a result waits
// or the coordinate unit runs. Reset clears the line state and the held
// reading; nothing needs clearing after reset, so the block is ready at once.

module nmea_gga_sentence_parser_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [7:0]    rx_byte,
    output logic               empty,
    input  wire logic          pop,
    output logic [1:0]         sentence_kind,
    output logic [2:0]         fix_quality,
    output logic [3:0]         satellite_count,
    output logic [3:0]         hdop_halves,
    output logic               position_valid,
    output logic signed [31:0] latitude_e7,
    output logic signed [31:0] longitude_e7,
    output logic signed [20:0] altitude_dm
);

    ngsp_pkg::qport_t     q;
    logic                 q_pop;
    ngsp_pkg::coord_req_t creq;
    ngsp_pkg::coord_rsp_t crsp;

    // The front end sorts bytes into start, end and data requests.
    ngsp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rx_byte (rx_byte),
        .full    (full),
        .q       (q),
        .q_pop   (q_pop)
    );

    // The coordinate unit turns ddmm.mmmmm pieces into degrees times 1e7.
    ngsp_coord u_coord (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    // The back end parses fields as bytes stream in and judges each line at
    // its close; it owns the held reading and the result register.
    ngsp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q               (q),
        .q_pop           (q_pop),
        .creq            (creq),
        .crsp            (crsp),
        .pop             (pop),
        .empty           (empty),
        .sentence_kind   (sentence_kind),
        .fix_quality     (fix_quality),
        .satellite_count (satellite_count),
        .hdop_halves     (hdop_halves),
        .position_valid  (position_valid),
        .latitude_e7     (latitude_e7),
        .longitude_e7    (longitude_e7),
        .altitude_dm     (altitude_dm)
    );

endmodule

`default_nettype wire

>>> hw/rtl/ngsp_front.sv
// Front end: byte classification and the request queue toward the parser.
`timescale 1ns / 1ps
`default_nettype none

module ngsp_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [7:0]       rx_byte,
    output logic                  full,
    output ngsp_pkg::qport_t      q,
    input  wire logic             q_pop
);

    ngsp_pkg::qent_t                 mem_reg [ngsp_pkg::QDEPTH];
    logic [ngsp_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ngsp_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [ngsp_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            push_ok, pop_ok;
    ngsp_pkg::cls_t                  cls;

    always_comb
    begin
        if (rx_byte == ngsp_pkg::CH_DOLLAR)
            cls = ngsp_pkg::CLS_START;
        else if (rx_byte == ngsp_pkg::CH_CR || rx_byte == ngsp_pkg::CH_LF)
            cls = ngsp_pkg::CLS_END;
        else
            cls = ngsp_pkg::CLS_DATA;
    end

    assign full    = (count_reg == ngsp_pkg::QCNT_W'(ngsp_pkg::QDEPTH));
    assign push_ok = push && !full;
    assign pop_ok  = q_pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
            wr_ptr_next = (wr_ptr_reg == ngsp_pkg::QPTR_W'(ngsp_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (pop_ok)
            rd_ptr_next = (rd_ptr_reg == ngsp_pkg::QPTR_W'(ngsp_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        if (push_ok && !pop_ok)
            count_next = count_reg + 1'b1;
        else if (!push_ok && pop_ok)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem_reg[wr_ptr_reg] <= '{cls: cls, ch: rx_byte};
    end

    assign q.valid = (count_reg != '0);
    assign q.cls   = mem_reg[rd_ptr_reg].cls;
    assign q.ch    = mem_reg[rd_ptr_reg].ch;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ngsp_pkg::QCNT_W'(ngsp_pkg::QDEPTH))
        else $error("request queue count above its depth");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!push_ok && !pop_ok) |=> $stable(count_reg))
        else $error("request queue count moved without a push or pop");

endmodule

`default_nettype wire

>>> hw/rtl/ngsp_coord.sv
// Multi-cycle converter from ddmm.mmmmm pieces to degrees times 1e7.
`timescale 1ns / 1ps
`default_nettype none

module ngsp_coord (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ngsp_pkg::coord_req_t req,
    output ngsp_pkg::coord_rsp_t      rsp
);

    localparam logic [1:0] PH_X   = 2'd0;
    localparam logic [1:0] PH_MUL = 2'd1;
    localparam logic [1:0] PH_SUM = 2'd2;

    ngsp_pkg::coord_raw_t lat_raw_reg, lon_raw_reg, cur;
    logic        sel_reg, busy_reg, valid_reg;
    logic [1:0]  ph_reg;
    logic [25:0] x5_reg;
    logic [57:0] prod_reg;
    logic [30:0] lat_mag_reg, lon_mag_reg;
    logic [25:0] x5;
    logic [24:0] quot;
    logic [33:0] total;
    logic [30:0] mag;

    assign cur  = sel_reg ? lon_raw_reg : lat_raw_reg;
    // Minutes and fraction in 1e-5 minute, times five; one third of it is the
    // minute part in 1e-7 degree.
    assign x5   = {19'd0, cur.min} * ngsp_pkg::MIN_SCALE5 + {9'd0, cur.frac} * 26'd5;
    assign quot = prod_reg[57:33];
    assign total = {26'd0, cur.deg} * ngsp_pkg::DEG_SCALE + {9'd0, quot};

    always_comb
    begin
        if (cur.zero)
            mag = '0;
        else if (cur.big || total > {3'd0, ngsp_pkg::COORD_LIMIT})
            mag = ngsp_pkg::COORD_LIMIT;
        else
            mag = total[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            ph_reg    <= PH_X;
        end
        else if (req.start)
        begin
            sel_reg   <= 1'b0;
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
            ph_reg    <= PH_X;
        end
        else if (busy_reg)
        begin
            unique case (ph_reg)
                PH_X:   ph_reg <= PH_MUL;
                PH_MUL: ph_reg <= PH_SUM;
                default:
                begin
                    ph_reg <= PH_X;
                    if (sel_reg)
                    begin
                        busy_reg  <= 1'b0;
                        valid_reg <= 1'b1;
                    end
                    sel_reg <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            lat_raw_reg <= req.lat;
            lon_raw_reg <= req.lon;
        end
        if (busy_reg && ph_reg == PH_X)
            x5_reg <= x5;
        if (busy_reg && ph_reg == PH_MUL)
            prod_reg <= {32'd0, x5_reg} * {26'd0, ngsp_pkg::DIV3_MUL};
        if (busy_reg && ph_reg == PH_SUM)
        begin
            if (sel_reg)
                lon_mag_reg <= mag;
            else
                lat_mag_reg <= mag;
        end
    end

    assign rsp.busy    = busy_reg;
    assign rsp.valid   = valid_reg;
    assign rsp.lat_mag = lat_mag_reg;
    assign rsp.lon_mag = lon_mag_reg;

    a_busy_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && valid_reg))
        else $error("coordinate unit busy and done at once");

endmodule

`default_nettype wire

>>> hw/rtl/ngsp_back.sv
// Back end: line tracking, streaming field parse, close checks and held reading.
`timescale 1ns / 1ps
`default_nettype none

module ngsp_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ngsp_pkg::qport_t     q,
    output logic                      q_pop,
    output ngsp_pkg::coord_req_t      creq,
    input  wire ngsp_pkg::coord_rsp_t crsp,
    input  wire logic                 pop,
    output logic                      empty,
    output logic [1:0]                sentence_kind,
    output logic [2:0]                fix_quality,
    output logic [3:0]                satellite_count,
    output logic [3:0]                hdop_halves,
    output logic                      position_valid,
    output logic signed [31:0]        latitude_e7,
    output logic signed [31:0]        longitude_e7,
    output logic signed [20:0]        altitude_dm
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CALC = 1'b1;

    localparam logic [1:0] ALT_RUN  = 2'd0;
    localparam logic [1:0] ALT_DOT  = 2'd1;
    localparam logic [1:0] ALT_DONE = 2'd2;

    localparam logic [3:0] FLD_LAT  = 4'd2;
    localparam logic [3:0] FLD_NS   = 4'd3;
    localparam logic [3:0] FLD_LON  = 4'd4;
    localparam logic [3:0] FLD_EW   = 4'd5;
    localparam logic [3:0] FLD_FIX  = 4'd6;
    localparam logic [3:0] FLD_SATS = 4'd7;
    localparam logic [3:0] FLD_HDOP = 4'd8;
    localparam logic [3:0] FLD_ALT  = 4'd9;

    // Parse state of the field being received.
    typedef struct packed {
        logic [7:0]  len;
        logic [7:0]  first;
        logic [7:0]  lead;
        logic        lead_run;
        logic [7:0]  deg;
        logic        big;
        logic [3:0]  mt;
        logic [3:0]  mo;
        logic        dot_seen;
        logic        dot_early;
        logic        frac_run;
        logic [2:0]  frac_cnt;
        logic [16:0] frac;
        logic [3:0]  tenth;
        logic [19:0] alt_v;
        logic        alt_neg;
        logic [1:0]  alt_ph;
        logic [3:0]  alt_t;
    } fld_t;

    // Candidate reading gathered from the closed fields of the line.
    typedef struct packed {
        ngsp_pkg::coord_raw_t lat;
        logic        ns_ok;
        logic        ns_s;
        ngsp_pkg::coord_raw_t lon;
        logic        ew_ok;
        logic        ew_w;
        logic [2:0]  fix;
        logic [3:0]  sats;
        logic [3:0]  hdop;
        logic [20:0] alt;
    } res_t;

    typedef struct packed {
        logic [ngsp_pkg::LEN_W-1:0] len;
        logic        overrun;
        logic        dollar0;
        logic        star_seen;
        logic [1:0]  after_star;
        logic [7:0]  hex_hi;
        logic [7:0]  hex_lo;
        logic [7:0]  xsum;
        logic        gga_ok;
        logic [3:0]  fidx;
        fld_t        fld;
        res_t        res;
    } line_t;

    function automatic fld_t fld_clear();
        fld_t f;
        f          = '0;
        f.lead_run = 1'b1;
        f.alt_ph   = ALT_RUN;
        return f;
    endfunction

    function automatic line_t line_clear();
        line_t l;
        l     = '0;
        l.fld = fld_clear();
        return l;
    endfunction

    function automatic fld_t fld_step(input fld_t f, input logic [7:0] c);
        fld_t        n;
        logic        dig;
        logic [3:0]  d;
        logic [11:0] lead_w;
        logic [11:0] deg_w;
        logic [23:0] alt_w;
        n      = f;
        dig    = ngsp_pkg::is_digit(c);
        d      = c[3:0];
        lead_w = {4'd0, f.lead} * 12'd10 + {8'd0, d};
        deg_w  = {4'd0, f.deg} * 12'd10 + {8'd0, f.mt};
        alt_w  = {4'd0, f.alt_v} * 24'd10 + {20'd0, d};
        if (f.len == 8'd0)
            n.first = c;
        // Leading digit run: capped value plus degree and minute split.
        if (f.lead_run)
        begin
            if (dig)
            begin
                n.lead = (lead_w > 12'd255) ? 8'd255 : lead_w[7:0];
                n.big  = f.big || (deg_w > 12'd255);
                n.deg  = deg_w[7:0];
                n.mt   = f.mo;
                n.mo   = d;
            end
            else
                n.lead_run = 1'b0;
        end
        // Fraction after the first dot, up to five digits.
        if (!f.dot_seen && c == ngsp_pkg::CH_DOT)
        begin
            n.dot_seen  = 1'b1;
            n.dot_early = (f.len < 8'd3);
            n.frac_run  = 1'b1;
        end
        else if (f.frac_run)
        begin
            if (dig && f.frac_cnt < 3'd5)
            begin
                n.frac     = f.frac + ngsp_pkg::frac_weight(f.frac_cnt) * {13'd0, d};
                n.frac_cnt = f.frac_cnt + 3'd1;
                if (f.frac_cnt == 3'd0)
                    n.tenth = d;
            end
            else
                n.frac_run = 1'b0;
        end
        // Altitude: optional sign, integer run, one kept tenth.
        unique case (f.alt_ph)
            ALT_RUN:
            begin
                if (f.len == 8'd0 && c == ngsp_pkg::CH_MINUS)
                    n.alt_neg = 1'b1;
                else if (dig)
                    n.alt_v = (alt_w > {4'd0, ngsp_pkg::ALT_LIMIT}) ?
                              ngsp_pkg::ALT_OVER : alt_w[19:0];
                else if (c == ngsp_pkg::CH_DOT)
                    n.alt_ph = ALT_DOT;
                else
                    n.alt_ph = ALT_DONE;
            end
            ALT_DOT:
            begin
                if (dig)
                    n.alt_t = d;
                n.alt_ph = ALT_DONE;
            end
            default:
            begin
                n.alt_ph = f.alt_ph;
            end
        endcase
        n.len = f.len + 8'd1;
        return n;
    endfunction

    function automatic res_t fld_close(input fld_t f, input logic [3:0] idx, input res_t r);
        res_t                 n;
        ngsp_pkg::coord_raw_t cr;
        logic [6:0]           hv;
        logic [14:0]          hp;
        logic [4:0]           hq;
        logic [3:0]           hdop;
        logic [23:0]          av;
        logic [19:0]          am;
        logic [20:0]          alt;
        n          = r;
        cr.present = (f.len != 8'd0);
        cr.zero    = f.dot_seen ? f.dot_early : (f.len < 8'd3);
        cr.big     = f.big;
        cr.deg     = f.deg;
        cr.min     = {3'd0, f.mt} * 7'd10 + {3'd0, f.mo};
        cr.frac    = f.frac;
        hv         = {4'd0, f.lead[2:0]} * 7'd10 + {3'd0, f.tenth} + 7'd2;
        hp         = {8'd0, hv} * 15'd205;
        hq         = hp[14:10];
        if (f.len == 8'd0)
            hdop = 4'd0;
        else if (f.lead >= 8'd8 || hq > 5'd15)
            hdop = 4'd15;
        else
            hdop = hq[3:0];
        av  = {4'd0, f.alt_v} * 24'd10 + {20'd0, f.alt_t};
        am  = (av > {4'd0, ngsp_pkg::ALT_LIMIT}) ? ngsp_pkg::ALT_LIMIT : av[19:0];
        if (f.len == 8'd0)
            alt = '0;
        else if (f.alt_neg)
            alt = 21'd0 - {1'b0, am};
        else
            alt = {1'b0, am};
        unique case (idx)
            FLD_LAT:  n.lat = cr;
            FLD_NS:
            begin
                n.ns_ok = cr.present;
                n.ns_s  = (f.first == ngsp_pkg::CH_S);
            end
            FLD_LON:  n.lon = cr;
            FLD_EW:
            begin
                n.ew_ok = cr.present;
                n.ew_w  = (f.first == ngsp_pkg::CH_W);
            end
            FLD_FIX:  n.fix  = (f.lead > 8'd7) ? 3'd7 : f.lead[2:0];
            FLD_SATS: n.sats = (f.lead > 8'd15) ? 4'd15 : f.lead[3:0];
            FLD_HDOP: n.hdop = hdop;
            FLD_ALT:  n.alt  = alt;
            default:  n.fix  = r.fix;
        endcase
        return n;
    endfunction

    // One byte stored into the line.
    function automatic line_t line_step(input line_t l, input logic [7:0] c);
        line_t n;
        n = l;
        if (l.len == 8'd0)
            n.dollar0 = (c == ngsp_pkg::CH_DOLLAR);
        if (l.len == 8'd3)
            n.gga_ok = (c == ngsp_pkg::CH_G);
        if (l.len == 8'd4)
            n.gga_ok = l.gga_ok && (c == ngsp_pkg::CH_G);
        if (l.len == 8'd5)
            n.gga_ok = l.gga_ok && (c == ngsp_pkg::CH_A);
        if (!l.star_seen)
        begin
            if (c == ngsp_pkg::CH_STAR)
                n.star_seen = 1'b1;
            else if (l.len != 8'd0)
                n.xsum = l.xsum ^ c;
            if (c == ngsp_pkg::CH_NUL || c == ngsp_pkg::CH_COMMA || c == ngsp_pkg::CH_STAR)
            begin
                n.res  = fld_close(l.fld, l.fidx, l.res);
                n.fidx = (l.fidx == 4'd15) ? 4'd15 : l.fidx + 4'd1;
                n.fld  = fld_clear();
            end
            else
                n.fld = fld_step(l.fld, c);
        end
        else
        begin
            if (l.after_star == 2'd0)
                n.hex_hi = c;
            if (l.after_star == 2'd1)
                n.hex_lo = c;
            if (l.after_star != 2'd2)
                n.after_star = l.after_star + 2'd1;
        end
        n.len = l.len + 8'd1;
        return n;
    endfunction

    logic        state_reg, state_next;
    line_t       line_reg, line_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [2:0]  held_fix_reg, held_fix_next;
    logic [3:0]  held_sats_reg, held_sats_next;
    logic [3:0]  held_hdop_reg, held_hdop_next;
    logic        held_pos_reg, held_pos_next;
    logic [31:0] held_lat_reg, held_lat_next;
    logic [31:0] held_lon_reg, held_lon_next;
    logic [20:0] held_alt_reg, held_alt_next;
    res_t        pend_reg, pend_next;

    logic        out_free, take;
    res_t        fin_res;
    logic [4:0]  hh, hl;
    logic        line_ok, pos_ok;
    logic [1:0]  close_kind;

    assign out_free = !out_valid_reg || pop;
    assign take     = (state_reg == ST_IDLE) && q.valid && out_free;

    // Close evaluation on the current line; an open field ends at line end.
    always_comb
    begin
        fin_res = line_reg.star_seen ? line_reg.res :
                  fld_close(line_reg.fld, line_reg.fidx, line_reg.res);
        hh      = ngsp_pkg::hex_val(line_reg.hex_hi);
        hl      = ngsp_pkg::hex_val(line_reg.hex_lo);
        line_ok = (line_reg.len >= 8'd6) && line_reg.dollar0 && line_reg.star_seen &&
                  (line_reg.after_star == 2'd2) && hh[4] && hl[4] &&
                  (line_reg.xsum == {hh[3:0], hl[3:0]});
        pos_ok  = (fin_res.fix != 3'd0) && fin_res.lat.present && fin_res.ns_ok &&
                  fin_res.lon.present && fin_res.ew_ok;
        if (line_reg.overrun)
            close_kind = ngsp_pkg::KIND_REJECTED;
        else if (line_reg.len == 8'd0)
            close_kind = ngsp_pkg::KIND_NONE;
        else if (!line_ok)
            close_kind = ngsp_pkg::KIND_REJECTED;
        else if (line_reg.gga_ok)
            close_kind = ngsp_pkg::KIND_GGA;
        else
            close_kind = ngsp_pkg::KIND_OTHER;
    end

    always_comb
    begin
        state_next     = state_reg;
        line_next      = line_reg;
        out_valid_next = out_valid_reg && !pop;
        out_kind_next  = out_kind_reg;
        held_fix_next  = held_fix_reg;
        held_sats_next = held_sats_reg;
        held_hdop_next = held_hdop_reg;
        held_pos_next  = held_pos_reg;
        held_lat_next  = held_lat_reg;
        held_lon_next  = held_lon_reg;
        held_alt_next  = held_alt_reg;
        pend_next      = pend_reg;
        q_pop          = 1'b0;
        creq.start     = 1'b0;
        creq.lat       = fin_res.lat;
        creq.lon       = fin_res.lon;

        if (take)
        begin
            q_pop          = 1'b1;
            out_valid_next = 1'b1;
            out_kind_next  = ngsp_pkg::KIND_NONE;
            unique case (q.cls)
                ngsp_pkg::CLS_START:
                    line_next = line_step(line_clear(), q.ch);
                ngsp_pkg::CLS_END:
                begin
                    line_next     = line_clear();
                    out_kind_next = close_kind;
                    if (close_kind == ngsp_pkg::KIND_GGA)
                    begin
                        if (pos_ok)
                        begin
                            creq.start     = 1'b1;
                            pend_next      = fin_res;
                            out_valid_next = 1'b0;
                            state_next     = ST_CALC;
                        end
                        else
                        begin
                            held_fix_next  = fin_res.fix;
                            held_sats_next = fin_res.sats;
                            held_hdop_next = fin_res.hdop;
                            held_pos_next  = 1'b0;
                            held_lat_next  = '0;
                            held_lon_next  = '0;
                            held_alt_next  = '0;
                        end
                    end
                end
                default:
                begin
                    if (!line_reg.overrun)
                    begin
                        if (line_reg.len >= ngsp_pkg::LEN_W'(ngsp_pkg::LINE_CAPACITY))
                            line_next.overrun = 1'b1;
                        else
                            line_next = line_step(line_reg, q.ch);
                    end
                end
            endcase
        end
        else if (state_reg == ST_CALC && crsp.valid && out_free)
        begin
            state_next     = ST_IDLE;
            out_valid_next = 1'b1;
            out_kind_next  = ngsp_pkg::KIND_GGA;
            held_fix_next  = pend_reg.fix;
            held_sats_next = pend_reg.sats;
            held_hdop_next = pend_reg.hdop;
            held_pos_next  = 1'b1;
            held_lat_next  = pend_reg.ns_s ? 32'd0 - {1'b0, crsp.lat_mag} : {1'b0, crsp.lat_mag};
            held_lon_next  = pend_reg.ew_w ? 32'd0 - {1'b0, crsp.lon_mag} : {1'b0, crsp.lon_mag};
            held_alt_next  = pend_reg.alt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            line_reg      <= line_clear();
            out_valid_reg <= 1'b0;
            out_kind_reg  <= ngsp_pkg::KIND_NONE;
            held_fix_reg  <= '0;
            held_sats_reg <= '0;
            held_hdop_reg <= '0;
            held_pos_reg  <= 1'b0;
            held_lat_reg  <= '0;
            held_lon_reg  <= '0;
            held_alt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            held_fix_reg  <= held_fix_next;
            held_sats_reg <= held_sats_next;
            held_hdop_reg <= held_hdop_next;
            held_pos_reg  <= held_pos_next;
            held_lat_reg  <= held_lat_next;
            held_lon_reg  <= held_lon_next;
            held_alt_reg  <= held_alt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    assign empty           = !out_valid_reg;
    assign sentence_kind   = out_kind_reg;
    assign fix_quality     = held_fix_reg;
    assign satellite_count = held_sats_reg;
    assign hdop_halves     = held_hdop_reg;
    assign position_valid  = held_pos_reg;
    assign latitude_e7     = held_lat_reg;
    assign longitude_e7    = held_lon_reg;
    assign altitude_dm     = held_alt_reg;

    a_no_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !held_pos_reg |-> (held_lat_reg == 32'd0 && held_lon_reg == 32'd0 &&
                           held_alt_reg == 21'd0))
        else $error("position fields nonzero without a position");

    a_calc_has_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> (crsp.busy || crsp.valid))
        else $error("waiting on coordinates with the unit idle");

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the NMEA GGA sentence parser core.
`timescale 1ns / 1ps

// The stimulus is a stream of received bytes. Most of it forms whole NMEA
// sentences with correct checksums: GGA lines with random field contents and
// lines of other types. The rest is broken on purpose: bad checksums, missing
// '$', truncated checksums, overlong lines, and random noise bytes. A
// behavioral copy of the parser predicts the result for every accepted
// request. The monitor compares each popped result with the oldest prediction.
module testbench;
    import ngsp_pkg::*;

    localparam int LINE_CAP = 128;
    localparam logic signed [31:0] COORD_MAX = 32'sd1810000000;
    localparam int ALT_MAX = 1000000;

    typedef struct packed {
        kind_t              kind;
        logic [2:0]         fixq;
        logic [3:0]         sats;
        logic [3:0]         hdop;
        logic               posv;
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic signed [20:0] alt;
    } reading_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [7:0] rx_byte;
    logic empty;
    logic pop;
    logic [1:0] sentence_kind;
    logic [2:0] fix_quality;
    logic [3:0] satellite_count;
    logic [3:0] hdop_halves;
    logic position_valid;
    logic signed [31:0] latitude_e7;
    logic signed [31:0] longitude_e7;
    logic signed [20:0] altitude_dm;

    nmea_gga_sentence_parser_core DUT (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .rx_byte(rx_byte),
        .empty(empty), .pop(pop),
        .sentence_kind(sentence_kind), .fix_quality(fix_quality),
        .satellite_count(satellite_count), .hdop_halves(hdop_halves),
        .position_valid(position_valid), .latitude_e7(latitude_e7),
        .longitude_e7(longitude_e7), .altitude_dm(altitude_dm)
    );

    // Pending bytes for the driver, and results the parser copy predicts.
    logic [7:0] byte_queue[$];
    reading_t   expected_readings[$];
    int         error_count = 0;
    int         byte_total = 0;
    int         gga_seen = 0;
    int         other_seen = 0;
    int         rejected_seen = 0;
    int         position_seen = 0;
    logic       stimulus_done = 1'b0;
    logic       pop_stall_long = 1'b0;
    logic       quiet_phase = 1'b0;

    // State of the behavioral parser copy.
    logic [7:0] line_buf[LINE_CAP];
    int         line_len = 0;
    logic       line_overrun = 1'b0;
    reading_t   held;

    function automatic logic digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    // Decimal value of up to len digits, saturating at 2^32-1.
    function automatic longint unsigned digits_value(input int pos, input int len);
        longint unsigned acc;
        acc = 0;
        for (int i = 0; i < len; i++) begin
            if (!digit_char(line_buf[pos + i])) break;
            acc = acc * 10 + (line_buf[pos + i] - "0");
            if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
        end
        return acc;
    endfunction

    function automatic int first_index(input int pos, input int len, input logic [7:0] ch);
        for (int i = 0; i < len; i++)
            if (line_buf[pos + i] == ch) return i;
        return len;
    endfunction

    // Locates field idx of the line; fields end at ',', '*' or a zero byte.
    function automatic logic locate_field(input int idx, output int st, output int sz);
        int cur;
        int start;
        logic [7:0] c;
        cur = 0;
        start = 0;
        st = 0;
        sz = 0;
        for (int i = 0; i <= line_len; i++) begin
            c = (i == line_len) ? CH_NUL : line_buf[i];
            if (c != CH_NUL && c != CH_COMMA && c != CH_STAR) continue;
            if (cur == idx) begin
                st = start;
                sz = i - start;
                return 1'b1;
            end
            cur++;
            start = i + 1;
            if (c == CH_STAR) break;
        end
        return 1'b0;
    endfunction

    // ddmm.mmmmm field to degrees times 1e7, magnitude only.
    function automatic longint coord_magnitude(input int pos, input int len);
        int dot;
        longint unsigned whole;
        longint unsigned frac;
        longint unsigned total;
        int nd;
        int i;
        dot = first_index(pos, len, CH_DOT);
        if (dot < 3) return 0;
        whole = digits_value(pos, dot);
        frac = 0;
        nd = 0;
        for (i = dot + 1; i < len && nd < 5; i++) begin
            if (!digit_char(line_buf[pos + i])) break;
            frac = frac * 10 + (line_buf[pos + i] - "0");
            nd++;
        end
        for (; nd < 5; nd++) frac = frac * 10;
        total = (whole / 100) * 10000000 + ((whole % 100) * 100000 + frac) * 5 / 3;
        if (total > COORD_MAX) total = COORD_MAX;
        return total;
    endfunction

    function automatic int altitude_decimetres(input int pos, input int len);
        int i;
        longint v;
        logic neg;
        i = 0;
        v = 0;
        neg = 1'b0;
        if (len == 0) return 0;
        if (line_buf[pos] == CH_MINUS) begin
            neg = 1'b1;
            i = 1;
        end
        for (; i < len && digit_char(line_buf[pos + i]); i++) begin
            v = v * 10 + (line_buf[pos + i] - "0");
            if (v > ALT_MAX) v = ALT_MAX + 1;
        end
        v = v * 10;
        if (i < len && line_buf[pos + i] == CH_DOT) begin
            i++;
            if (i < len && digit_char(line_buf[pos + i])) v = v + (line_buf[pos + i] - "0");
        end
        if (v > ALT_MAX) v = ALT_MAX;
        return neg ? -int'(v) : int'(v);
    endfunction

    // A valid GGA line replaces the whole held reading.
    task automatic update_held_reading();
        int s, n, ls, ln, ns, nn, os, on, es, en, dot;
        longint unsigned units, tenths, h, q;
        longint lat, lon;
        held = '0;
        if (locate_field(6, s, n)) begin
            q = digits_value(s, n);
            held.fixq = q > 7 ? 3'd7 : q[2:0];
        end
        if (locate_field(7, s, n)) begin
            q = digits_value(s, n);
            held.sats = q > 15 ? 4'd15 : q[3:0];
        end
        if (locate_field(8, s, n) && n > 0) begin
            dot = first_index(s, n, CH_DOT);
            units = digits_value(s, dot);
            tenths = (dot + 1 < n) ? digits_value(s + dot + 1, 1) : 0;
            h = (units * 10 + tenths + 2) / 5;
            held.hdop = h > 15 ? 4'd15 : h[3:0];
        end
        if (held.fixq == 0) return;
        if (!locate_field(2, ls, ln) || ln == 0 || !locate_field(3, ns, nn) || nn == 0 ||
            !locate_field(4, os, on) || on == 0 || !locate_field(5, es, en) || en == 0)
            return;
        lat = coord_magnitude(ls, ln);
        lon = coord_magnitude(os, on);
        held.lat = (line_buf[ns] == CH_S) ? -lat : lat;
        held.lon = (line_buf[es] == CH_W) ? -lon : lon;
        held.posv = 1'b1;
        if (locate_field(9, s, n)) held.alt = altitude_decimetres(s, n);
    endtask

    task automatic judge_line(output kind_t kind);
        int star, hi, lo;
        logic [7:0] sum;
        kind = KIND_REJECTED;
        if (line_len < 6 || line_buf[0] != CH_DOLLAR) return;
        star = first_index(0, line_len, CH_STAR);
        if (star + 2 >= line_len) return;
        sum = 8'h00;
        for (int i = 1; i < star; i++) sum ^= line_buf[i];
        hi = hex_digit(line_buf[star + 1]);
        lo = hex_digit(line_buf[star + 2]);
        if (hi < 0 || lo < 0 || sum != hi * 16 + lo) return;
        if (line_buf[3] == CH_G && line_buf[4] == CH_G && line_buf[5] == CH_A) begin
            update_held_reading();
            kind = KIND_GGA;
        end else begin
            kind = KIND_OTHER;
        end
    endtask

    // Advances the parser copy by one byte and returns the predicted result.
    task automatic predict_byte(input logic [7:0] c, output reading_t r);
        kind_t kind;
        kind = KIND_NONE;
        if (c == CH_DOLLAR) begin
            line_overrun = 1'b0;
            line_buf[0] = c;
            line_len = 1;
        end else if (c == CH_CR || c == CH_LF) begin
            if (line_overrun) kind = KIND_REJECTED;
            else if (line_len > 0) judge_line(kind);
            line_len = 0;
            line_overrun = 1'b0;
        end else if (!line_overrun) begin
            if (line_len >= LINE_CAP) line_overrun = 1'b1;
            else begin
                line_buf[line_len] = c;
                line_len++;
            end
        end
        r = held;
        r.kind = kind;
    endtask

    // ---------------- Stimulus construction ----------------

    function automatic string digit_run(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string hex2(input logic [7:0] v, input logic lower);
        string s;
        s = lower ? $sformatf("%02h", v) : $sformatf("%02H", v);
        return s;
    endfunction

    // Queues "$body*CS" plus a line end; the checksum may be corrupted.
    task automatic queue_sentence(input string body, input logic corrupt);
        logic [7:0] sum;
        string line;
        sum = 8'h00;
        for (int i = 0; i < body.len(); i++) sum ^= body[i];
        if (corrupt) sum ^= 8'(1 << $urandom_range(0, 7));
        line = {"$", body, "*", hex2(sum, $urandom_range(0, 3) == 0)};
        for (int i = 0; i < line.len(); i++) byte_queue.push_back(line[i]);
        case ($urandom_range(0, 2))
            0: byte_queue.push_back(CH_CR);
            1: byte_queue.push_back(CH_LF);
            default:
            begin
                byte_queue.push_back(CH_CR);
                byte_queue.push_back(CH_LF);
            end
        endcase
    endtask

    function automatic string coord_text(input int deg_digits);
        string s;
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return "";
        if (r == 1) return {digit_run(2), ".", digit_run(3)};
        if (r == 2) return {"9", digit_run(deg_digits + 1), ".99999"};
        s = {digit_run(deg_digits + 2), ".", digit_run($urandom_range(0, 7))};
        if (r == 3) s = digit_run(deg_digits + 2);
        return s;
    endfunction

    function automatic string random_gga_body();
        string t, alt, hd;
        int r;
        r = $urandom_range(0, 5);
        hd = (r == 0) ? "" : (r == 1) ? digit_run($urandom_range(1, 3))
           : {digit_run($urandom_range(0, 2)), ".", digit_run($urandom_range(0, 2))};
        r = $urandom_range(0, 6);
        alt = (r == 0) ? "" : (r == 1) ? {"-", digit_run($urandom_range(1, 8))}
            : {($urandom_range(0, 2) == 0) ? "-" : "", digit_run($urandom_range(1, 7)),
               ".", digit_run($urandom_range(0, 3))};
        t = {"GPGGA,", digit_run(6), ".00,", coord_text(2), ",",
             ($urandom_range(0, 1) ? "S" : "N"), ",", coord_text(3), ",",
             ($urandom_range(0, 1) ? "W" : "E"), ",",
             ($urandom_range(0, 5) == 0) ? "0" : digit_run($urandom_range(1, 2)), ",",
             digit_run($urandom_range(0, 3)), ",", hd, ",", alt, ",M,0.0,M,,"};
        if ($urandom_range(0, 7) == 0) t = t.substr(0, $urandom_range(6, t.len() - 1));
        return t;
    endfunction

    function automatic string random_other_body();
        string s;
        int n;
        n = $urandom_range(2, 40);
        s = ($urandom_range(0, 1)) ? "GPRMC," : "GNGSA,";
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(32, 126)))};
        // Keep '$' and '*' out of the body so the line stays well formed.
        for (int i = 0; i < s.len(); i++)
            if (s[i] == CH_DOLLAR || s[i] == CH_STAR) s[i] = CH_COMMA;
        return s;
    endfunction

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
    endtask

    initial
    begin
        // Directed part: a textbook fix, the hemisphere signs, saturations,
        // a no-fix line, an empty close, missing '$', bad checksum digits,
        // a short line, an overrun and a line of another type.
        queue_sentence("GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,", 1'b0);
        queue_sentence("GPGGA,1,9959.99999,S,18059.99999,W,9,99,99.9,-99999999.9,M,,", 1'b0);
        queue_sentence("GPGGA,1,12.5,S,1,W,3,4,,12.34,M", 1'b0);
        queue_sentence("GPGGA,1,4807.038,N,01131.000,E,0,05,1.2,10,M", 1'b0);
        queue_sentence("GPGGA,1,4807.038,N,,E,2,05,1.2,10,M", 1'b0);
        queue_sentence("GPRMC,123519,A", 1'b0);
        queue_sentence("GPGGA,1,4807.038,N,01131.000,E,1,08,0.9,545.4,M", 1'b1);
        byte_queue.push_back(CH_CR);
        queue_text("GPGGA,1,2*00");
        byte_queue.push_back(CH_LF);
        queue_text("$GPGGA*4G");
        byte_queue.push_back(CH_CR);
        queue_text("$GP*");
        byte_queue.push_back(CH_LF);
        byte_queue.push_back(CH_DOLLAR);
        for (int i = 0; i < LINE_CAP + 5; i++) byte_queue.push_back(8'h31);
        byte_queue.push_back(CH_CR);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(CH_LF);

        // Random part: mostly well-formed sentences, some broken ones and noise.
        while (byte_queue.size() < 1950) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: queue_sentence(random_gga_body(), $urandom_range(0, 9) == 0);
                5, 6: queue_sentence(random_other_body(), $urandom_range(0, 5) == 0);
                7:
                begin
                    for (int i = $urandom_range(1, 12); i > 0; i--)
                        byte_queue.push_back(8'($urandom_range(0, 255)));
                end
                8:
                begin
                    byte_queue.push_back(CH_DOLLAR);
                    for (int i = $urandom_range(LINE_CAP - 2, LINE_CAP + 3); i > 0; i--)
                        byte_queue.push_back(8'h41);
                    byte_queue.push_back(CH_LF);
                end
                default: queue_text(random_gga_body());
            endcase
        end
        stimulus_done = 1'b1;
    end

    // ---------------- Clock and reset ----------------

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Quiet stretch with no idling on either side.
    initial
    begin
        quiet_phase = 1'b0;
        wait (rst_n);
        repeat (3000) @(posedge clk);
        quiet_phase <= 1'b1;
        repeat (1500) @(posedge clk);
        quiet_phase <= 1'b0;
    end

    // Long receiver hold-off, counted here, so the request queue fills up.
    initial
    begin
        wait (rst_n);
        repeat (200) @(posedge clk);
        pop_stall_long <= 1'b1;
        repeat (300) @(posedge clk);
        pop_stall_long <= 1'b0;
    end

    // ---------------- Driver ----------------

    // A request is accepted when push is high and full is low at an edge;
    // the prediction is made at that same edge from the byte being offered.
    always @(posedge clk or negedge rst_n)
    begin
        reading_t r;
        logic offer;
        if (!rst_n) begin
            push <= 1'b0;
            rx_byte <= 8'h00;
        end else begin
            offer = push;
            if (push && !full) begin
                predict_byte(rx_byte, r);
                expected_readings.push_back(r);
                void'(byte_queue.pop_front());
                byte_total++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (byte_queue.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 30)) begin
                    push <= 1'b1;
                    rx_byte <= byte_queue[0];
                end else begin
                    push <= 1'b0;
                    rx_byte <= 8'($urandom_range(0, 255));
                end
            end
        end
    end

    // ---------------- Monitor ----------------

    always @(posedge clk or negedge rst_n)
    begin
        reading_t exp_r;
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t: result popped with no request pending, kind %0d",
                             $realtime, sentence_kind);
                    error_count++;
                end else begin
                    exp_r = expected_readings.pop_front();
                    case (exp_r.kind)
                        KIND_GGA: gga_seen++;
                        KIND_OTHER: other_seen++;
                        KIND_REJECTED: rejected_seen++;
                        default: ;
                    endcase
                    if (exp_r.kind == KIND_GGA && exp_r.posv) position_seen++;
                    if (sentence_kind !== exp_r.kind) begin
                        $display("%0t: sentence_kind expected %0d actual %0d",
                                 $realtime, exp_r.kind, sentence_kind);
                        error_count++;
                    end
                    if (fix_quality !== exp_r.fixq) begin
                        $display("%0t: fix_quality expected %0d actual %0d",
                                 $realtime, exp_r.fixq, fix_quality);
                        error_count++;
                    end
                    if (satellite_count !== exp_r.sats) begin
                        $display("%0t: satellite_count expected %0d actual %0d",
                                 $realtime, exp_r.sats, satellite_count);
                        error_count++;
                    end
                    if (hdop_halves !== exp_r.hdop) begin
                        $display("%0t: hdop_halves expected %0d actual %0d",
                                 $realtime, exp_r.hdop, hdop_halves);
                        error_count++;
                    end
                    if (position_valid !== exp_r.posv) begin
                        $display("%0t: position_valid expected %0d actual %0d",
                                 $realtime, exp_r.posv, position_valid);
                        error_count++;
                    end
                    if (latitude_e7 !== exp_r.lat) begin
                        $display("%0t: latitude_e7 expected %0d actual %0d",
                                 $realtime, exp_r.lat, latitude_e7);
                        error_count++;
                    end
                    if (longitude_e7 !== exp_r.lon) begin
                        $display("%0t: longitude_e7 expected %0d actual %0d",
                                 $realtime, exp_r.lon, longitude_e7);
                        error_count++;
                    end
                    if (altitude_dm !== exp_r.alt) begin
                        $display("%0t: altitude_dm expected %0d actual %0d",
                                 $realtime, exp_r.alt, altitude_dm);
                        error_count++;
                    end
                end
            end
            pop <= !pop_stall_long && (quiet_phase || $urandom_range(0, 99) >= 30);
        end
    end

    // ---------------- End of run ----------------

    initial
    begin
        wait (rst_n);
        wait (stimulus_done && byte_queue.size() == 0 && expected_readings.size() == 0);
        // Allow for the coordinate unit to finish anything still in flight.
        repeat (40) @(posedge clk);
        $display("Covered %0d bytes: %0d GGA closes (%0d with position), %0d other, %0d rejected.",
                 byte_total, gga_seen, position_seen, other_seen, rejected_seen);
        if (error_count == 0 && expected_readings.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Run timed out with %0d results outstanding.", expected_readings.size());
        $display("testbench: done, errors");
        $finish;
    end

endmodule
